// ===== design/pcc_pkg.sv =====
// Shared types, constants and helpers of the priority character compositor.
// No dependencies; every other design file but pcc_ram refers to it by scoped names.
package pcc_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH     = 128;
  localparam int MAX_HEIGHT    = 64;
  localparam int PRIORITY_BITS = 16;
  localparam int CELLS         = MAX_WIDTH * MAX_HEIGHT;
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int ADDR_W        = $clog2(CELLS);

  // Register and field widths
  localparam int SW_W   = 8;
  localparam int SH_W   = 7;
  localparam int CRD_W  = 16;
  localparam int CHAR_W = 8;
  localparam int LYR_W  = 16;
  localparam int RR_W   = 6;
  localparam int RC_W   = 7;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;
  // Screen coordinates after mapping, wide enough to never overflow
  localparam int POS_W  = 20;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_TRANSPARENT = 8'd0;
  localparam logic [CHAR_W-1:0] CH_NEWLINE     = 8'd10;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [IDX_W-1:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_CAMERA_X       = 3'd2,
    REG_CAMERA_Y       = 3'd3,
    REG_BLANK_CHAR     = 3'd4,
    REG_FLOOR_PRIORITY = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW,
    ST_READ
  } state_e;

  // Configuration register file contents
  typedef struct packed {
    logic [SW_W-1:0]          screen_width;
    logic [SH_W-1:0]          screen_height;
    logic signed [CRD_W-1:0]  camera_x;
    logic signed [CRD_W-1:0]  camera_y;
    logic [CHAR_W-1:0]        blank_char;
    logic [LYR_W-1:0]         floor_priority;
  } cfg_t;

  // Result of mapping one request onto the frame
  typedef struct packed {
    logic              draw_vis;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] read_addr;
    logic              read_inside;
    logic              read_row_end;
  } map_t;

  // One frame store word
  typedef struct packed {
    logic [CHAR_W-1:0]        ch;
    logic [PRIORITY_BITS-1:0] prio;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // Linear cell address from screen row and column
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
  endfunction

endpackage

// ===== design/pcc_intf.sv =====
// Handshake channels of the compositor: request, result and register write.
// Depends on pcc_pkg for field widths.
interface pcc_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [pcc_pkg::CRD_W-1:0] image_x;
  logic signed [pcc_pkg::CRD_W-1:0] image_y;
  logic [7:0]                       pixel_row;
  logic [7:0]                       pixel_col;
  logic [pcc_pkg::CHAR_W-1:0]       pixel_char;
  logic [pcc_pkg::LYR_W-1:0]        layer_priority;
  logic                             sprite_active;
  logic [pcc_pkg::RR_W-1:0]         read_row;
  logic [pcc_pkg::RC_W-1:0]         read_col;

  modport source (output valid, command, image_x, image_y, pixel_row, pixel_col,
                  pixel_char, layer_priority, sprite_active, read_row, read_col,
                  input ready);
  modport sink (input valid, command, image_x, image_y, pixel_row, pixel_col,
                pixel_char, layer_priority, sprite_active, read_row, read_col,
                output ready);
endinterface

interface pcc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pcc_pkg::CHAR_W-1:0] cell_char;
  logic                       row_end;

  modport source (output valid, cell_char, row_end, input ready);
  modport sink (input valid, cell_char, row_end, output ready);
endinterface

interface pcc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pcc_pkg::IDX_W-1:0]  index;
  logic [pcc_pkg::DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/priority_character_compositor_top.sv =====
// Priority character compositor: frame store with per-cell priority, FSM.
// Depends on pcc_pkg, pcc_intf, pcc_ram, pcc_cfg and pcc_map.
//
// One request is handled at a time. A draw request whose cell lands on screen
// and is opaque reads the stored priority, then does the conditional write
// back through the single frame memory; a dropped draw or a no-op returns
// straight to idle. A read loads the output register once no earlier result
// waits in it. A clear sweeps the whole store, one cell a cycle, and so
// holds off requests until every cell has been written.
// The store holds no defined contents until the first clear; register writes
// are taken at any time and should only be issued while the block is idle.
module priority_character_compositor_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_req_if.sink   req_i,
  pcc_rsp_if.source rsp_o,
  pcc_cfg_if.sink   cfg_i
);

  localparam int AW = pcc_pkg::ADDR_W;

  pcc_pkg::cfg_t   cfg;
  pcc_pkg::map_t   map;
  pcc_pkg::state_e state_q, state_d;

  logic [AW-1:0]                     addr_q, addr_d;
  logic [AW-1:0]                     cnt_q, cnt_d;
  logic [pcc_pkg::CHAR_W-1:0]        char_q, char_d;
  logic [pcc_pkg::PRIORITY_BITS-1:0] prio_q, prio_d;
  logic                              inside_q, inside_d;
  logic                              rowend_q, rowend_d;
  logic                              row_skip_q, row_skip_d;
  logic                              out_valid_q, out_valid_d;
  logic [pcc_pkg::CHAR_W-1:0]        out_char_q, out_char_d;
  logic                              out_rowend_q, out_rowend_d;

  logic              accept;
  pcc_pkg::cmd_e     cmd;
  logic              skip_eff;
  logic              draw_go;
  logic              load_out;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  pcc_pkg::cell_t    ram_wdata;
  pcc_pkg::cell_t    ram_rdata;

  pcc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pcc_map u_map (
    .cfg_i       (cfg),
    .image_x_i   (req_i.image_x),
    .image_y_i   (req_i.image_y),
    .pixel_row_i (req_i.pixel_row),
    .pixel_col_i (req_i.pixel_col),
    .read_row_i  (req_i.read_row),
    .read_col_i  (req_i.read_col),
    .map_o       (map)
  );

  pcc_ram #(
    .WIDTH (pcc_pkg::CELL_W),
    .DEPTH (pcc_pkg::CELLS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cmd    = pcc_pkg::cmd_e'(req_i.command);
  assign accept = req_i.valid && req_i.ready;

  // Draw filtering: a new sprite row restarts, a visible newline ends the row
  always_comb begin
    skip_eff = (req_i.pixel_col == '0) ? 1'b0 : row_skip_q;
    draw_go  = req_i.sprite_active && !skip_eff && map.draw_vis
             && (req_i.pixel_char != pcc_pkg::CH_TRANSPARENT)
             && (req_i.pixel_char != pcc_pkg::CH_NEWLINE);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcc_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            pcc_pkg::CMD_CLEAR: state_d = pcc_pkg::ST_CLEAR;
            pcc_pkg::CMD_DRAW:  state_d = draw_go ? pcc_pkg::ST_DRAW : pcc_pkg::ST_IDLE;
            pcc_pkg::CMD_READ:  state_d = pcc_pkg::ST_READ;
            default:            state_d = pcc_pkg::ST_IDLE;
          endcase
        end
      end
      pcc_pkg::ST_CLEAR: begin
        if (cnt_q == AW'(pcc_pkg::CELLS - 1)) begin
          state_d = pcc_pkg::ST_IDLE;
        end
      end
      pcc_pkg::ST_DRAW: state_d = pcc_pkg::ST_IDLE;
      pcc_pkg::ST_READ: begin
        if (load_out) begin
          state_d = pcc_pkg::ST_IDLE;
        end
      end
      default: state_d = pcc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory port, output register load
  always_comb begin
    req_i.ready = (state_q == pcc_pkg::ST_IDLE);
    load_out    = (state_q == pcc_pkg::ST_READ) && (!out_valid_q || rsp_o.ready);
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '{ch: char_q, prio: prio_q};
    case (state_q)
      pcc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
      end
      pcc_pkg::ST_DRAW: begin
        ram_we = (prio_q >= ram_rdata.prio);
      end
      default: ;
    endcase
    // Read address follows the request while idle, then holds
    if (state_q == pcc_pkg::ST_IDLE) begin
      ram_raddr = (cmd == pcc_pkg::CMD_READ) ? map.read_addr : map.draw_addr;
    end else begin
      ram_raddr = addr_q;
    end
  end

  // Request capture
  always_comb begin
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    char_d     = char_q;
    prio_d     = prio_q;
    inside_d   = inside_q;
    rowend_d   = rowend_q;
    row_skip_d = row_skip_q;
    if (state_q == pcc_pkg::ST_CLEAR) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (accept) begin
      addr_d   = ram_raddr;
      inside_d = map.read_inside;
      rowend_d = map.read_row_end;
      cnt_d    = '0;
      case (cmd)
        pcc_pkg::CMD_CLEAR: begin
          char_d     = cfg.blank_char;
          prio_d     = cfg.floor_priority[pcc_pkg::PRIORITY_BITS-1:0];
          row_skip_d = 1'b0;
        end
        pcc_pkg::CMD_DRAW: begin
          char_d = req_i.pixel_char;
          prio_d = req_i.layer_priority[pcc_pkg::PRIORITY_BITS-1:0];
          if (req_i.sprite_active) begin
            row_skip_d = skip_eff
                       || (map.draw_vis && (req_i.pixel_char == pcc_pkg::CH_NEWLINE));
          end
        end
        pcc_pkg::CMD_READ: begin
          char_d = cfg.blank_char;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_char_d   = out_char_q;
    out_rowend_d = out_rowend_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_char_d   = inside_q ? ram_rdata.ch : char_q;
      out_rowend_d = rowend_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.cell_char = out_char_q;
  assign rsp_o.row_end   = out_rowend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcc_pkg::ST_IDLE;
      cnt_q       <= '0;
      row_skip_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_skip_q  <= row_skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    char_q       <= char_d;
    prio_q       <= prio_d;
    inside_q     <= inside_d;
    rowend_q     <= rowend_d;
    out_char_q   <= out_char_d;
    out_rowend_q <= out_rowend_d;
  end

endmodule

// ===== design/pcc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/pcc_cfg.sv =====
// Configuration register file of the compositor, written over the cfg channel.
// Depends on pcc_pkg and pcc_cfg_if.
module pcc_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  pcc_cfg_if.sink         cfg_i,
  output pcc_pkg::cfg_t   cfg_o
);

  pcc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (pcc_pkg::reg_idx_e'(cfg_i.index))
        pcc_pkg::REG_SCREEN_WIDTH:   cfg_d.screen_width   = cfg_i.data[pcc_pkg::SW_W-1:0];
        pcc_pkg::REG_SCREEN_HEIGHT:  cfg_d.screen_height  = cfg_i.data[pcc_pkg::SH_W-1:0];
        pcc_pkg::REG_CAMERA_X:       cfg_d.camera_x       = $signed(cfg_i.data);
        pcc_pkg::REG_CAMERA_Y:       cfg_d.camera_y       = $signed(cfg_i.data);
        pcc_pkg::REG_BLANK_CHAR:     cfg_d.blank_char     = cfg_i.data[pcc_pkg::CHAR_W-1:0];
        pcc_pkg::REG_FLOOR_PRIORITY: cfg_d.floor_priority = cfg_i.data[pcc_pkg::LYR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width   <= 8'd80;
      cfg_q.screen_height  <= 7'd25;
      cfg_q.camera_x       <= '0;
      cfg_q.camera_y       <= '0;
      cfg_q.blank_char     <= 8'd32;
      cfg_q.floor_priority <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/pcc_map.sv =====
// Maps a sprite cell through the camera origin onto the frame and decodes
// read positions. Depends on pcc_pkg.
module pcc_map (
  input  pcc_pkg::cfg_t                     cfg_i,
  input  logic signed [pcc_pkg::CRD_W-1:0]  image_x_i,
  input  logic signed [pcc_pkg::CRD_W-1:0]  image_y_i,
  input  logic [7:0]                        pixel_row_i,
  input  logic [7:0]                        pixel_col_i,
  input  logic [pcc_pkg::RR_W-1:0]          read_row_i,
  input  logic [pcc_pkg::RC_W-1:0]          read_col_i,
  output pcc_pkg::map_t                     map_o
);

  localparam int PW = pcc_pkg::POS_W;

  logic [pcc_pkg::SW_W-1:0] vis_w;
  logic [pcc_pkg::SH_W-1:0] vis_h;
  logic signed [PW-1:0]     row;
  logic signed [PW-1:0]     col;

  // Visible window, clipped to the store
  always_comb begin
    vis_w = (32'(cfg_i.screen_width) < pcc_pkg::MAX_WIDTH) ? cfg_i.screen_width
                                                            : pcc_pkg::SW_W'(pcc_pkg::MAX_WIDTH);
    vis_h = (32'(cfg_i.screen_height) < pcc_pkg::MAX_HEIGHT) ? cfg_i.screen_height
                                                              : pcc_pkg::SH_W'(pcc_pkg::MAX_HEIGHT);
  end

  // Screen position: y grows downward on screen, upward in the world
  always_comb begin
    row = PW'(cfg_i.camera_y) + $signed({(PW-pcc_pkg::SH_W+1)'(0), vis_h[pcc_pkg::SH_W-1:1]})
        - PW'(image_y_i) + $signed({(PW-8)'(0), pixel_row_i});
    col = PW'(image_x_i) - PW'(cfg_i.camera_x)
        + $signed({(PW-pcc_pkg::SW_W+1)'(0), vis_w[pcc_pkg::SW_W-1:1]})
        + $signed({(PW-8)'(0), pixel_col_i});
  end

  always_comb begin
    map_o.draw_vis = !row[PW-1] && !col[PW-1]
                   && (row < $signed({(PW-pcc_pkg::SH_W)'(0), vis_h}))
                   && (col < $signed({(PW-pcc_pkg::SW_W)'(0), vis_w}));
    map_o.draw_addr = pcc_pkg::cell_addr(row[pcc_pkg::ROW_W-1:0], col[pcc_pkg::COL_W-1:0]);
    map_o.read_inside = (32'(read_row_i) < pcc_pkg::MAX_HEIGHT)
                      && (32'(read_col_i) < pcc_pkg::MAX_WIDTH);
    map_o.read_addr = pcc_pkg::cell_addr(pcc_pkg::ROW_W'(read_row_i),
                                         pcc_pkg::COL_W'(read_col_i));
    map_o.read_row_end = (vis_w != '0)
                       && ({1'b0, read_col_i} == pcc_pkg::SW_W'(vis_w - 1'b1));
  end

endmodule
